// ===== rtl/core/q4k_pkg.sv =====
// Shared types, constants and binary32 arithmetic helpers for the Q4_K dequantiser.
package q4k_pkg;

  localparam int BLOCK_BYTES   = 144;
  localparam int HEADER_BYTES  = 16;
  localparam int PACKED_COUNT  = 12;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // one quant byte, classified and ready for the arithmetic side
  typedef struct packed {
    logic [31:0] scale_f;
    logic [31:0] min_f;
    logic [5:0]  sc_lo;
    logic [5:0]  mn_lo;
    logic [5:0]  sc_hi;
    logic [5:0]  mn_hi;
    logic [3:0]  nib_lo;
    logic [3:0]  nib_hi;
    logic [7:0]  index;
    logic        last;
  } job_t;

  // subtract after alignment, before normalisation
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic [8:0]  exp;
    logic [27:0] mant;
  } add_mid_t;

  function automatic logic [31:0] half_to_f(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  k;
    logic [32:0] t;
    logic [31:0] r;
    e = h[14:10];
    m = h[9:0];
    k = 4'd0;
    t = 33'd0;
    if (e == 5'd0) begin
      if (m == 10'd0) begin
        r = {h[15], 31'd0};
      end else begin
        // subnormal: m * 2^-24, renormalised
        for (int i = 0; i < 10; i++) begin
          if (m[i]) k = 4'(i);
        end
        t = {23'd0, m} << (5'd23 - {1'b0, k});
        r = {h[15], 8'(8'd103 + {4'd0, k}), t[22:0]};
      end
    end else if (e == 5'd31) begin
      r = (m != 10'd0) ? CANON_NAN : {h[15], 8'hFF, 23'd0};
    end else begin
      r = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] small_to_f(input logic [5:0] n);
    logic [2:0]  k;
    logic [28:0] t;
    logic [31:0] r;
    k = 3'd0;
    t = 29'd0;
    for (int i = 0; i < 6; i++) begin
      if (n[i]) k = 3'(i);
    end
    if (n == 6'd0) begin
      r = 32'd0;
    end else begin
      t = {23'd0, n} << (5'd23 - {2'd0, k});
      r = {1'b0, 8'(8'd127 + {5'd0, k}), t[22:0]};
    end
    return r;
  endfunction

  // operands here are zero, normal, infinite or NaN; products stay in normal range
  function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, g, st, up;
    logic [47:0] p;
    logic [9:0]  e;
    logic [22:0] mt;
    logic [23:0] rr;
    logic [31:0] r;
    s      = a[31] ^ b[31];
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    p  = 48'({1'b1, a[22:0]}) * 48'({1'b1, b[22:0]});
    e  = 10'({2'd0, a[30:23]} + {2'd0, b[30:23]} - 10'd127);
    if (p[47]) begin
      mt = p[46:24];
      g  = p[23];
      st = |p[22:0];
      e  = e + 10'd1;
    end else begin
      mt = p[45:23];
      g  = p[22];
      st = |p[21:0];
    end
    up = g && (st || mt[0]);
    rr = {1'b0, mt} + {23'd0, up};
    if (rr[23]) e = e + 10'd1;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      r = CANON_NAN;
    end else if (a_inf || b_inf) begin
      r = {s, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      r = {s, 31'd0};
    end else begin
      r = {s, e[7:0], rr[22:0]};
    end
    return r;
  endfunction

  // a - b: specials, swap, align, add or subtract
  function automatic add_mid_t f_sub_align(input logic [31:0] a, input logic [31:0] b);
    logic        bs, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sticky;
    logic [31:0] nb, big, sml;
    logic [26:0] mbig, msm, sh, al, mask;
    logic [7:0]  d;
    add_mid_t    r;
    bs     = ~b[31];
    nb     = {bs, b[30:0]};
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    big    = (b[30:0] > a[30:0]) ? nb : a;
    sml    = (b[30:0] > a[30:0]) ? a : nb;
    mbig   = {1'b1, big[22:0], 3'd0};
    msm    = {1'b1, sml[22:0], 3'd0};
    d      = big[30:23] - sml[30:23];
    if (d >= 8'd27) begin
      sh     = 27'd0;
      sticky = 1'b1;
    end else begin
      mask   = (27'd1 << d[4:0]) - 27'd1;
      sh     = msm >> d[4:0];
      sticky = |(msm & mask);
    end
    al         = {sh[26:1], sh[0] | sticky};
    r.spec     = 1'b0;
    r.spec_val = 32'd0;
    r.sign     = big[31];
    r.exp      = {1'b0, big[30:23]};
    if (big[31] == sml[31]) r.mant = {1'b0, mbig} + {1'b0, al};
    else                    r.mant = {1'b0, mbig} - {1'b0, al};
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != bs))) begin
      r.spec     = 1'b1;
      r.spec_val = CANON_NAN;
    end else if (a_inf) begin
      r.spec     = 1'b1;
      r.spec_val = a;
    end else if (b_inf) begin
      r.spec     = 1'b1;
      r.spec_val = nb;
    end else if (a_zero && b_zero) begin
      r.spec     = 1'b1;
      r.spec_val = {a[31] & bs, 31'd0};
    end else if (a_zero) begin
      r.spec     = 1'b1;
      r.spec_val = nb;
    end else if (b_zero) begin
      r.spec     = 1'b1;
      r.spec_val = a;
    end else if (r.mant == 28'd0) begin
      // exact cancellation gives +0
      r.spec     = 1'b1;
      r.spec_val = 32'd0;
    end
    return r;
  endfunction

  // normalise and round to nearest even
  function automatic logic [31:0] f_sub_norm(input add_mid_t m);
    logic [4:0]  l;
    logic [27:0] t;
    logic [26:0] n;
    logic [8:0]  e;
    logic        up;
    logic [23:0] rr;
    logic [31:0] r;
    l = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (m.mant[i]) l = 5'(i);
    end
    if (l == 5'd27) begin
      n = {m.mant[27:2], m.mant[1] | m.mant[0]};
      e = m.exp + 9'd1;
    end else begin
      t = m.mant << (5'd26 - l);
      n = t[26:0];
      e = m.exp - {4'd0, 5'd26 - l};
    end
    up = n[2] && (n[1] || n[0] || n[3]);
    rr = {1'b0, n[25:3]} + {23'd0, up};
    if (rr[23]) e = e + 9'd1;
    r = m.spec ? m.spec_val : {m.sign, e[7:0], rr[22:0]};
    return r;
  endfunction

endpackage

// ===== rtl/core/q4k_block_dequantizer_core.sv =====
// Top level of the Q4_K block dequantiser: front end, job queue, arithmetic back end.
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid / s_tready | s_tdata[7:0] = data_byte
//  m_*     | out | m_tvalid / m_tready | m_tdata = elem_index, value_low, value_high;
//          |     |                     | m_tlast = block_last
//
// Header bytes (16 per 144-byte block) transfer at one per cycle and give no result.
// In the back end each quant byte takes one step to take the job from the queue,
// six passes through the one shared binary32 multiplier and two two-step subtracts,
// the last subtract step also loading the output register.
// The queue (QUEUE_DEPTH jobs) lets the front keep taking bytes while the back works.
// Reset (rst, synchronous) returns to the start of a block and empties queue and output.
// A stalled m_tready holds the finished result; the back end then stops in its last step.
module q4k_block_dequantizer_core #(
  parameter int QUEUE_DEPTH = q4k_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [7:0] elem_index, [39:8] value_low, [71:40] value_high
  output logic        m_tlast    // block_last
);

  q4k_pkg::job_t f_job;
  q4k_pkg::job_t b_job;
  logic          f_valid;
  logic          f_ready;
  logic          b_valid;
  logic          b_ready;
  logic [7:0]    o_index;
  logic [31:0]   o_low;
  logic [31:0]   o_high;

  q4k_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  q4k_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  q4k_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (o_index),
    .out_low   (o_low),
    .out_high  (o_high),
    .out_last  (m_tlast)
  );

  assign m_tdata = {o_high, o_low, o_index};

endmodule

// ===== rtl/core/q4k_front.sv =====
// Front end: tracks block position, keeps header bytes, classifies quant bytes into jobs.
module q4k_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              job_valid,
  input  logic              job_ready,
  output q4k_pkg::job_t     job
);

  logic [7:0]  pos;
  logic [7:0]  pos_next;
  logic [15:0] scale_half;
  logic [15:0] min_half;
  logic [7:0]  pk [q4k_pkg::PACKED_COUNT];
  logic [5:0]  sc [8];
  logic [5:0]  mn [8];
  logic        is_header;
  logic        take;
  logic [6:0]  p;
  logic [7:0]  pk_off;
  logic [2:0]  j_lo;
  logic [2:0]  j_hi;

  assign is_header = (pos < 8'(q4k_pkg::HEADER_BYTES));
  assign in_ready  = is_header || job_ready;
  assign take      = in_valid && in_ready;
  assign job_valid = in_valid && !is_header;
  assign pos_next  = (pos == 8'(q4k_pkg::BLOCK_BYTES - 1)) ? 8'd0 : pos + 8'd1;
  assign pk_off    = pos - 8'd4;
  assign p         = 7'(pos - 8'(q4k_pkg::HEADER_BYTES));
  assign j_lo      = {p[6:5], 1'b0};
  assign j_hi      = {p[6:5], 1'b1};

  // 6-bit scale/min unpacking, fixed wiring per sub-block
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sc[j]     = pk[j][5:0];
      mn[j]     = pk[j + 4][5:0];
      sc[j + 4] = {pk[j][7:6], pk[j + 8][3:0]};
      mn[j + 4] = {pk[j + 4][7:6], pk[j + 8][7:4]};
    end
  end

  always_comb begin
    job.scale_f = q4k_pkg::half_to_f(scale_half);
    job.min_f   = q4k_pkg::half_to_f(min_half);
    job.sc_lo   = sc[j_lo];
    job.mn_lo   = mn[j_lo];
    job.sc_hi   = sc[j_hi];
    job.mn_hi   = mn[j_hi];
    job.nib_lo  = in_byte[3:0];
    job.nib_hi  = in_byte[7:4];
    job.index   = {p[6:5], 1'b0, p[4:0]};
    job.last    = (p == 7'd127);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 8'd0;
    end else if (take) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (pos)
        8'd0:    scale_half[7:0]  <= in_byte;
        8'd1:    scale_half[15:8] <= in_byte;
        8'd2:    min_half[7:0]    <= in_byte;
        8'd3:    min_half[15:8]   <= in_byte;
        default: begin
          if (is_header) pk[pk_off[3:0]] <= in_byte;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/q4k_queue.sv =====
// Short job queue between the front end and the arithmetic back end.
module q4k_queue #(
  parameter int DEPTH = q4k_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  q4k_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output q4k_pkg::job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q4k_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (do_pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

// ===== rtl/core/q4k_back.sv =====
// Back end: sequenced binary32 multiply/subtract on one shared multiplier, output register.
module q4k_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  q4k_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_index,
  output logic [31:0]   out_low,
  output logic [31:0]   out_high,
  output logic          out_last
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_M3   = 4'd4;
  localparam logic [3:0] ST_M4   = 4'd5;
  localparam logic [3:0] ST_M5   = 4'd6;
  localparam logic [3:0] ST_A0   = 4'd7;
  localparam logic [3:0] ST_A1   = 4'd8;
  localparam logic [3:0] ST_A2   = 4'd9;
  localparam logic [3:0] ST_A3   = 4'd10;

  logic [3:0]        state;
  logic [3:0]        state_next;
  q4k_pkg::job_t     cur;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       mul_r;
  logic [31:0]       d1_lo, m1_lo, d1_hi, m1_hi, p_lo, p_hi, v_lo;
  q4k_pkg::add_mid_t mid;
  logic              out_free;

  assign job_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    case (state)
      ST_M0:   begin mul_a = cur.scale_f; mul_b = q4k_pkg::small_to_f(cur.sc_lo); end
      ST_M1:   begin mul_a = cur.min_f;   mul_b = q4k_pkg::small_to_f(cur.mn_lo); end
      ST_M2:   begin mul_a = cur.scale_f; mul_b = q4k_pkg::small_to_f(cur.sc_hi); end
      ST_M3:   begin mul_a = cur.min_f;   mul_b = q4k_pkg::small_to_f(cur.mn_hi); end
      ST_M4:   begin mul_a = d1_lo; mul_b = q4k_pkg::small_to_f({2'd0, cur.nib_lo}); end
      ST_M5:   begin mul_a = d1_hi; mul_b = q4k_pkg::small_to_f({2'd0, cur.nib_hi}); end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  assign mul_r = q4k_pkg::f_mul(mul_a, mul_b);

  always_comb begin
    case (state)
      ST_IDLE: state_next = job_valid ? ST_M0 : ST_IDLE;
      ST_A3:   state_next = out_free ? ST_IDLE : ST_A3;
      default: state_next = state + 4'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_A3 && out_free) out_valid <= 1'b1;
      else if (out_ready)             out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (job_valid) cur <= job;
      ST_M0:   d1_lo <= mul_r;
      ST_M1:   m1_lo <= mul_r;
      ST_M2:   d1_hi <= mul_r;
      ST_M3:   m1_hi <= mul_r;
      ST_M4:   p_lo  <= mul_r;
      ST_M5:   p_hi  <= mul_r;
      ST_A0:   mid   <= q4k_pkg::f_sub_align(p_lo, m1_lo);
      ST_A1:   v_lo  <= q4k_pkg::f_sub_norm(mid);
      ST_A2:   mid   <= q4k_pkg::f_sub_align(p_hi, m1_hi);
      ST_A3: begin
        if (out_free) begin
          out_index <= cur.index;
          out_low   <= v_lo;
          out_high  <= q4k_pkg::f_sub_norm(mid);
          out_last  <= cur.last;
        end
      end
      default: ;
    endcase
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job_ready) |=> (state == ST_M0))
    else $error("job taken but sequence not started");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_A3 && out_valid && !out_ready) |=> (state == ST_A3))
    else $error("result overwrote an untaken output");

  a_nan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_low[30:23] != 8'hFF) || (out_low[22:0] == 23'd0)
                   || (out_low == q4k_pkg::CANON_NAN)))
    else $error("non-canonical NaN on output");

  a_one_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_A3 && out_free) |=> out_valid)
    else $error("finished result not presented");

endmodule
